// ===== sv/epc_pkg.sv =====
// Shared constants and tables for the epoch seconds to calendar converter.
// No dependencies.
package epc_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // floor(2^35 / 675), applied to seconds >> 7 (86400 = 128 * 675)
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;
    localparam int          DAY_SHIFT  = 35;
    // ceil(2^27 / 3600) and ceil(2^18 / 60), exact over their input ranges
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;
    // floor(2^21 / 1461), off by at most one, corrected after
    localparam logic [10:0] QUAD_RECIP = 11'd1435;
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;
    // ceil(2^11 / 7), exact below 682
    localparam logic [8:0]  WD_RECIP   = 9'd293;

    // days from 1968-01-01 to 1970-01-01, and to 2100-03-01
    localparam logic [15:0] BASE_OFFSET  = 16'd731;
    localparam logic [15:0] SKIP_LEAP_AT = 16'd48272;
    localparam logic [11:0] BASE_YEAR    = 12'd1968;
    localparam logic [11:0] RANGE_YEAR   = 12'd2100;

    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        if (leap && idx >= 4'd2) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    function automatic logic [2:0] month_fix(input logic [3:0] idx);
        logic [2:0] f;
        case (idx)
            4'd0:    f = 3'd0;
            4'd1:    f = 3'd3;
            4'd2:    f = 3'd3;
            4'd3:    f = 3'd6;
            4'd4:    f = 3'd1;
            4'd5:    f = 3'd4;
            4'd6:    f = 3'd6;
            4'd7:    f = 3'd2;
            4'd8:    f = 3'd5;
            4'd9:    f = 3'd0;
            4'd10:   f = 3'd3;
            default: f = 3'd5;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/epc_day_split.sv =====
// Stages 1-2: splits seconds into day number and seconds within the day.
// Depends on epc_pkg.
module epc_day_split (
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  logic [31:0] i_secs,
    output logic [15:0] o_days,
    output logic [16:0] o_rem
);
    import epc_pkg::*;

    logic [31:0] r_secs;
    logic [50:0] r_prod;
    logic [15:0] r_days;
    logic [16:0] r_rem;

    logic [15:0] n_q0;
    logic [32:0] n_back;
    logic [32:0] n_diff;
    logic        n_big;

    always_comb begin
        n_q0   = r_prod[50:DAY_SHIFT];
        n_back = 33'(n_q0) * 33'(SECS_PER_DAY);
        n_diff = 33'(r_secs) - n_back;
        n_big  = n_diff >= 33'(SECS_PER_DAY);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_secs <= i_secs;
            r_prod <= 51'(i_secs[31:7]) * 51'(DAY_RECIP);
        end
        if (i_en[1]) begin
            r_days <= n_big ? n_q0 + 16'd1 : n_q0;
            r_rem  <= n_big ? 17'(n_diff - 33'(SECS_PER_DAY)) : n_diff[16:0];
        end
    end

    assign o_days = r_days;
    assign o_rem  = r_rem;
endmodule

// ===== sv/epc_tod.sv =====
// Stages 3-6: hour, minute and second from seconds within the day.
// Depends on epc_pkg.
module epc_tod (
    input  logic        i_clk,
    input  logic [3:0]  i_en,
    input  logic [16:0] i_rem,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import epc_pkg::*;

    logic [16:0] r3_rem;
    logic [31:0] r3_ph;
    logic [4:0]  r4_hour;
    logic [11:0] r4_r2;
    logic [4:0]  r5_hour;
    logic [11:0] r5_r2;
    logic [23:0] r5_pm;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_min;
    logic [5:0]  r6_sec;

    logic [4:0]  n_hour;
    logic [5:0]  n_min;

    assign n_hour = r3_ph[31:27];
    assign n_min  = r5_pm[23:18];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r3_rem <= i_rem;
            r3_ph  <= 32'(i_rem) * 32'(HOUR_RECIP);
        end
        if (i_en[1]) begin
            r4_hour <= n_hour;
            r4_r2   <= 12'(r3_rem - 17'(n_hour) * 17'(SECS_PER_HOUR));
        end
        if (i_en[2]) begin
            r5_hour <= r4_hour;
            r5_r2   <= r4_r2;
            r5_pm   <= 24'(r4_r2) * 24'(MIN_RECIP);
        end
        if (i_en[3]) begin
            r6_hour <= r5_hour;
            r6_min  <= n_min;
            r6_sec  <= 6'(r5_r2 - 12'(n_min) * 12'(SECS_PER_MIN));
        end
    end

    assign o_hour   = r6_hour;
    assign o_minute = r6_min;
    assign o_second = r6_sec;
endmodule

// ===== sv/epc_date.sv =====
// Stages 3-6: year, month index and day of month from the day number.
// Depends on epc_pkg.
module epc_date (
    input  logic        i_clk,
    input  logic [3:0]  i_en,
    input  logic [15:0] i_days,
    output logic [11:0] o_year,
    output logic [3:0]  o_mon_idx,
    output logic [4:0]  o_day
);
    import epc_pkg::*;

    logic [15:0] r3_dp;
    logic [26:0] r3_py;
    logic [5:0]  r4_q;
    logic [10:0] r4_r;
    logic [11:0] r5_year;
    logic [8:0]  r5_doy;
    logic        r5_leap;
    logic [11:0] r6_year;
    logic [3:0]  r6_mon;
    logic [4:0]  r6_day;

    logic [15:0] n_d;
    logic [15:0] n_dp;
    logic [5:0]  n_q0;
    logic [16:0] n_r;
    logic        n_big;
    logic [1:0]  n_yib;
    logic [10:0] n_doy;
    logic [3:0]  n_mon;

    always_comb begin
        n_d  = i_days + BASE_OFFSET;
        // 2100 is not leap: step over its missing Feb 29
        n_dp = (n_d >= SKIP_LEAP_AT) ? n_d + 16'd1 : n_d;
        n_q0  = r3_py[26:21];
        n_r   = 17'(r3_dp) - 17'(n_q0) * 17'(QUAD_DAYS);
        n_big = n_r >= 17'(QUAD_DAYS);
        if (r4_r < 11'd366) begin
            n_yib = 2'd0;
            n_doy = r4_r;
        end else if (r4_r < 11'd731) begin
            n_yib = 2'd1;
            n_doy = r4_r - 11'd366;
        end else if (r4_r < 11'd1096) begin
            n_yib = 2'd2;
            n_doy = r4_r - 11'd731;
        end else begin
            n_yib = 2'd3;
            n_doy = r4_r - 11'd1096;
        end
        n_mon = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r5_doy >= month_start(4'(k), r5_leap)) begin
                n_mon = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r3_dp <= n_dp;
            r3_py <= 27'(n_dp) * 27'(QUAD_RECIP);
        end
        if (i_en[1]) begin
            r4_q <= n_big ? n_q0 + 6'd1 : n_q0;
            r4_r <= n_big ? 11'(n_r - 17'(QUAD_DAYS)) : n_r[10:0];
        end
        if (i_en[2]) begin
            r5_year <= BASE_YEAR + {4'd0, r4_q, 2'b00} + 12'(n_yib);
            r5_doy  <= n_doy[8:0];
            r5_leap <= (n_yib == 2'd0);
        end
        if (i_en[3]) begin
            r6_year <= r5_year;
            r6_mon  <= n_mon;
            r6_day  <= 5'(r5_doy - month_start(n_mon, r5_leap) + 9'd1);
        end
    end

    assign o_year    = r6_year;
    assign o_mon_idx = r6_mon;
    assign o_day     = r6_day;
endmodule

// ===== sv/epoch_seconds_to_calendar_top.sv =====
// Epoch seconds to calendar date, time of day and weekday.
// Requests pass through eight register stages from input request to output request.
// One request per cycle unless stalled; each stage holds on its own stall.
// Reset (synchronous, active low) clears all stage valid bits.
// Depends on epc_pkg, epc_day_split, epc_tod, epc_date.
module epoch_seconds_to_calendar_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // seconds_count
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // year, month, day_of_month, hour, minute, second, weekday, zero pad
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser   // out_of_range
);
    import epc_pkg::*;

    logic [8:1]  r_v;
    logic [8:1]  n_en;

    logic [15:0] w_days;
    logic [16:0] w_rem;
    logic [4:0]  w_hour;
    logic [5:0]  w_min;
    logic [5:0]  w_sec;
    logic [11:0] w_year;
    logic [3:0]  w_mon;
    logic [4:0]  w_day;

    logic [11:0] r7_year;
    logic [3:0]  r7_mon;
    logic [4:0]  r7_day;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;
    logic [8:0]  r7_wsum;
    logic [11:0] r8_year;
    logic [3:0]  r8_month;
    logic [4:0]  r8_day;
    logic [4:0]  r8_hour;
    logic [5:0]  r8_min;
    logic [5:0]  r8_sec;
    logic [2:0]  r8_wd;
    logic        r8_oor;

    logic [7:0]  n_lo;
    logic        n_dec;
    logic [8:0]  n_wsum;
    logic [16:0] n_wq;
    logic [8:0]  n_wd;

    always_comb begin
        n_en[8] = !r_v[8] || i_m_axis_tready;
        for (int k = 7; k >= 1; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    epc_day_split u_split (
        .i_clk  (i_clk),
        .i_en   (n_en[2:1]),
        .i_secs (i_s_axis_tdata),
        .o_days (w_days),
        .o_rem  (w_rem)
    );

    epc_tod u_tod (
        .i_clk    (i_clk),
        .i_en     (n_en[6:3]),
        .i_rem    (w_rem),
        .o_hour   (w_hour),
        .o_minute (w_min),
        .o_second (w_sec)
    );

    epc_date u_date (
        .i_clk     (i_clk),
        .i_en      (n_en[6:3]),
        .i_days    (w_days),
        .o_year    (w_year),
        .o_mon_idx (w_mon),
        .o_day     (w_day)
    );

    // two-digit year plus 100 past 1999, table formula is exact up to 2099
    always_comb begin
        n_lo   = (w_year < RANGE_YEAR) ? 8'(w_year - 12'd1900) : 8'(w_year - 12'd2000);
        n_dec  = (n_lo[1:0] == 2'b00) && (w_mon < 4'd2);
        n_wsum = 9'(n_lo) + 9'(n_lo[7:2]) + 9'(w_day) + 9'(month_fix(w_mon)) - 9'(n_dec);
        n_wq   = 17'(r7_wsum) * 17'(WD_RECIP);
        n_wd   = r7_wsum - 9'(n_wq[16:11]) * 9'd7;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[7]) begin
            r7_year <= w_year;
            r7_mon  <= w_mon;
            r7_day  <= w_day;
            r7_hour <= w_hour;
            r7_min  <= w_min;
            r7_sec  <= w_sec;
            r7_wsum <= n_wsum;
        end
        if (n_en[8]) begin
            r8_year  <= r7_year;
            r8_month <= r7_mon + 4'd1;
            r8_day   <= r7_day;
            r8_hour  <= r7_hour;
            r8_min   <= r7_min;
            r8_sec   <= r7_sec;
            r8_wd    <= n_wd[2:0];
            r8_oor   <= r7_year >= RANGE_YEAR;
        end
    end

    assign o_s_axis_tready = n_en[1];
    assign o_m_axis_tvalid = r_v[8];
    assign o_m_axis_tdata  = {7'd0, r8_wd, r8_sec, r8_min, r8_hour, r8_day, r8_month, r8_year};
    assign o_m_axis_tuser  = r8_oor;

`ifndef ASSERT_OFF
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] |-> (r8_month >= 4'd1 && r8_month <= 4'd12))
        else $error("month out of range");
    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] |-> (r8_wd < 3'd7 && r8_hour < 5'd24 && r8_min < 6'd60 && r8_sec < 6'd60))
        else $error("time or weekday out of range");
    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[8] |-> (r8_oor == (r8_year >= RANGE_YEAR)))
        else $error("range flag mismatch");
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[7] && !n_en[7]) |=> r_v[7])
        else $error("stalled stage lost its request");
`endif
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for epoch_seconds_to_calendar_top: directed boundary
// dates, then random counts, each checked field by field against a local
// calendar predictor. Depends on epc_pkg and the converter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import epc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic        late;
    } t_cal;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // seconds_count
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // year, month, day, hour, minute, second, weekday, pad
    logic        o_m_axis_tuser;   // out_of_range

    t_cal        pending_dates[$];
    int          errors;
    int          sent;
    int          checked;
    int          cycles;
    bit          no_idle;
    int          ready_hold;

    epoch_seconds_to_calendar_top u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic t_cal to_calendar(logic [31:0] secs);
        t_cal        c;
        int unsigned days, rem, yr, mon, len, lo, t;
        int unsigned fix[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
        int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        days = secs / 86400;
        rem  = secs % 86400;
        yr   = 1970;
        mon  = 0;
        forever begin
            len = is_leap(yr) ? 366 : 365;
            if (days < len) break;
            days -= len;
            yr++;
        end
        while (mon < 11) begin
            len = mlen[mon];
            if (mon == 1 && is_leap(yr)) len = 29;
            if (days < len) break;
            days -= len;
            mon++;
        end
        lo = yr % 100;
        if (yr / 100 > 19) lo += 100;
        t = (lo + lo / 4) % 7 + days + 1 + fix[mon];
        if (lo % 4 == 0 && mon < 2) t -= 1;
        c.year   = yr[11:0];
        c.month  = 4'(mon + 1);
        c.mday   = 5'(days + 1);
        c.hour   = 5'(rem / 3600);
        c.minute = 6'((rem % 3600) / 60);
        c.second = 6'(rem % 60);
        c.wday   = 3'(t % 7);
        c.late   = (yr >= 2100);
        return c;
    endfunction

    function automatic logic [31:0] year_start(int unsigned y);
        longint unsigned d;
        d = 0;
        for (int unsigned k = 1970; k < y; k++) d += is_leap(k) ? 366 : 365;
        return 32'(d * 86400);
    endfunction

    task automatic send_seconds(logic [31:0] secs);
        int gap;
        gap = (!no_idle && $urandom_range(3) == 0) ? $urandom_range(11, 1) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_dates.push_back(to_calendar(secs));
        sent++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_cal exp_c, got;
            got = {o_m_axis_tdata[11:0], o_m_axis_tdata[15:12], o_m_axis_tdata[20:16],
                   o_m_axis_tdata[25:21], o_m_axis_tdata[31:26], o_m_axis_tdata[37:32],
                   o_m_axis_tdata[40:38], o_m_axis_tuser};
            if (pending_dates.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_c = pending_dates.pop_front();
                checked++;
                if (got.year !== exp_c.year)
                    $display("%0t year exp %0d got %0d", $time, exp_c.year, got.year);
                if (got.month !== exp_c.month)
                    $display("%0t month exp %0d got %0d", $time, exp_c.month, got.month);
                if (got.mday !== exp_c.mday)
                    $display("%0t day exp %0d got %0d", $time, exp_c.mday, got.mday);
                if (got.hour !== exp_c.hour)
                    $display("%0t hour exp %0d got %0d", $time, exp_c.hour, got.hour);
                if (got.minute !== exp_c.minute)
                    $display("%0t minute exp %0d got %0d", $time, exp_c.minute, got.minute);
                if (got.second !== exp_c.second)
                    $display("%0t second exp %0d got %0d", $time, exp_c.second, got.second);
                if (got.wday !== exp_c.wday)
                    $display("%0t weekday exp %0d got %0d", $time, exp_c.wday, got.wday);
                if (got.late !== exp_c.late)
                    $display("%0t range exp %0d got %0d", $time, exp_c.late, got.late);
                if (got !== exp_c) errors++;
            end
        end
        if (no_idle) begin
            i_m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(4) == 0) begin
            i_m_axis_tready <= ~i_m_axis_tready;
            ready_hold      <= $urandom_range(11, 1) - 1;
        end
    end

    task automatic test_boundaries();
        logic [31:0] dates[$] = '{32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400,
            32'd94608000, 32'd825552000, 32'd951782400, 32'd978220800,
            32'd2147483647, 32'd2147483648, 32'd4102444799, 32'd4102444800,
            32'd4107456000, 32'd4107542400, 32'd4107542399, 32'd68169599,
            32'd68169600, 32'd5097599, 32'd5097600};
        foreach (dates[i]) send_seconds(dates[i]);
    endtask

    task automatic test_random(int count);
        logic [31:0] base, secs;
        int unsigned y;
        for (int i = 0; i < count; i++) begin
            if (i > count - 150) no_idle = 1'b1;
            case ($urandom_range(3))
                0, 1: secs = $urandom;
                2: begin
                    y    = $urandom_range(2106, 1970);
                    base = year_start(y);
                    case ($urandom_range(3))
                        0: secs = base;
                        1: secs = base - 32'(86400 * $urandom_range(2));
                        2: secs = base + 32'(86400 * $urandom_range(60, 57));
                        default: secs = base + 32'(86400 * $urandom_range(366, 364));
                    endcase
                    secs = secs + 32'($urandom_range(86399));
                end
                default: secs = 32'hFFFF_FFFF - 32'($urandom_range(40000000));
            endcase
            send_seconds(secs);
        end
    endtask

    initial begin
        errors = 0; sent = 0; checked = 0; cycles = 0;
        no_idle = 1'b0; ready_hold = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundaries();
        test_random(1900);
        i_s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d counts sent, %0d results checked: epoch, leap-year ends, 2038,",
                 sent, checked);
        $display("2100 range edge, top of count, random counts under random stalls");
        if (errors == 0 && pending_dates.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
